>>> sv/n64as_pkg.sv
// shared types, constants and byte placement functions for nat64 address synthesis
`timescale 1ns / 1ps

package n64as_pkg;

  localparam int unsigned ADDR_BYTES = 16;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned V4_W       = 32;
  localparam int unsigned CODE_W     = 3;

  // well-known ipv4 addresses 192.0.0.170 and 192.0.0.171 differ in the last bit only
  localparam logic [7:0] WK_OCT0 = 8'd192;
  localparam logic [7:0] WK_OCT1 = 8'd0;
  localparam logic [7:0] WK_OCT2 = 8'd0;
  localparam logic [7:0] WK_OCT3 = 8'd170;
  localparam logic [7:0] WK_OCT3_MASK = 8'hFE;

  // byte 0 of the ipv6 address sits at index 0, the most significant byte
  typedef logic [0:ADDR_BYTES-1][7:0] addr_bytes_t;
  typedef logic [0:3][7:0]            v4_bytes_t;

  typedef enum logic [CODE_W-1:0] {
    PFX_32    = 3'd0,
    PFX_40    = 3'd1,
    PFX_48    = 3'd2,
    PFX_56    = 3'd3,
    PFX_64    = 3'd4,
    PFX_96    = 3'd5,
    PFX_UNREC = 3'd6
  } prefix_code_t;

  // status handed from the classifier to the pipeline
  typedef struct packed {
    prefix_code_t code;
    logic         u_octet;
  } class_t;

  function automatic logic is_wk(input v4_bytes_t v);
    is_wk = (v[0] == WK_OCT0) && (v[1] == WK_OCT1) && (v[2] == WK_OCT2) &&
            ((v[3] & WK_OCT3_MASK) == WK_OCT3);
  endfunction

  // pick the four bytes that carry the ipv4 address for a prefix
  function automatic v4_bytes_t pick_v4(input addr_bytes_t b, input prefix_code_t code);
    v4_bytes_t v;
    unique case (code)
      PFX_32:  v = {b[4], b[5], b[6], b[7]};
      PFX_40:  v = {b[5], b[6], b[7], b[9]};
      PFX_48:  v = {b[6], b[7], b[9], b[10]};
      PFX_56:  v = {b[7], b[9], b[10], b[11]};
      PFX_64:  v = {b[9], b[10], b[11], b[12]};
      default: v = {b[12], b[13], b[14], b[15]};
    endcase
    return v;
  endfunction

  // write the ipv4 address over the same positions, u-octet cleared where used
  function automatic addr_bytes_t place_v4(input addr_bytes_t b, input v4_bytes_t v,
                                           input prefix_code_t code, input logic u_oct);
    addr_bytes_t r;
    r = b;
    unique case (code)
      PFX_32: begin
        r[4] = v[0]; r[5] = v[1]; r[6] = v[2]; r[7] = v[3];
      end
      PFX_40: begin
        r[5] = v[0]; r[6] = v[1]; r[7] = v[2]; r[9] = v[3];
      end
      PFX_48: begin
        r[6] = v[0]; r[7] = v[1]; r[9] = v[2]; r[10] = v[3];
      end
      PFX_56: begin
        r[7] = v[0]; r[9] = v[1]; r[10] = v[2]; r[11] = v[3];
      end
      PFX_64: begin
        r[9] = v[0]; r[10] = v[1]; r[11] = v[2]; r[12] = v[3];
      end
      default: begin
        r[12] = v[0]; r[13] = v[1]; r[14] = v[2]; r[15] = v[3];
      end
    endcase
    if (u_oct) begin
      r[8] = 8'd0;
    end
    return r;
  endfunction

endpackage

>>> sv/n64as_classify.sv
// trailing zero byte count of the ipv6 address mapped to a prefix code
`timescale 1ns / 1ps

module n64as_classify (
  input  n64as_pkg::addr_bytes_t addr,
  output n64as_pkg::class_t      cls
);
  import n64as_pkg::*;

  logic [ADDR_BYTES-1:0] zb;

  always_comb begin
    for (int i = 0; i < ADDR_BYTES; i++) begin
      zb[i] = (addr[i] == 8'd0);
    end
  end

  // exact trailing zero counts 0, 3, 4, 5, 6 and 8 are recognized
  always_comb begin
    priority if (!zb[15]) begin
      cls.code = PFX_96;
    end else if (zb[14] && zb[13] && !zb[12]) begin
      cls.code = PFX_64;
    end else if (zb[14] && zb[13] && zb[12] && !zb[11]) begin
      cls.code = PFX_56;
    end else if (zb[14] && zb[13] && zb[12] && zb[11] && !zb[10]) begin
      cls.code = PFX_48;
    end else if (zb[14] && zb[13] && zb[12] && zb[11] && zb[10] && !zb[9]) begin
      cls.code = PFX_40;
    end else if (&zb[14:8] && !zb[7]) begin
      cls.code = PFX_32;
    end else begin
      cls.code = PFX_UNREC;
    end
    cls.u_octet = (cls.code == PFX_40) || (cls.code == PFX_48) || (cls.code == PFX_56);
  end

endmodule

>>> sv/nat64_ipv6_address_synthesis.sv
// top level: three-stage pipeline that embeds an ipv4 address into a nat64 ipv6 address
`timescale 1ns / 1ps

// Takes one transaction per clock while the output side does not stall and returns one
// result per transaction, in order. Stage one counts the trailing zero bytes of the
// 128-bit address and infers the prefix (/32, /40, /48, /56, /64 or /96, else
// unrecognized); stage two checks that 192.0.0.170 or 192.0.0.171 sits at that
// prefix's position, with the u-octet (byte 8) required to be zero for /40, /48 and
// /56; stage three writes the given ipv4 address into the same bytes and registers
// the result. An unrecognized count places the ipv4 address in bytes 12 to 15,
// reports prefix code 6 and clears addr_valid; a failed check still embeds the
// address. Each stage holds its own valid bit and advances whenever the stage after
// it is empty or moving, so a stall on the output backs up stage by stage and loses
// nothing; in_stall rises only when all three stages hold transactions and the
// output is stalled.
module nat64_ipv6_address_synthesis (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [n64as_pkg::HALF_W-1:0]        in_synth_addr_hi,
  input  logic [n64as_pkg::HALF_W-1:0]        in_synth_addr_lo,
  input  logic [n64as_pkg::V4_W-1:0]          in_ipv4_addr,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [n64as_pkg::HALF_W-1:0]        out_result_addr_hi,
  output logic [n64as_pkg::HALF_W-1:0]        out_result_addr_lo,
  output logic [n64as_pkg::CODE_W-1:0]        out_prefix_code,
  output logic                                out_addr_valid
);
  import n64as_pkg::*;

  // stage one: classified address
  logic        s1_v_r;
  addr_bytes_t s1_addr_r;
  v4_bytes_t   s1_v4_r;
  class_t      s1_cls_r;

  // stage two: well-known check done
  logic        s2_v_r;
  addr_bytes_t s2_addr_r;
  v4_bytes_t   s2_v4_r;
  class_t      s2_cls_r;
  logic        s2_ok_r;

  // stage three: output registers
  logic         out_v_r;
  addr_bytes_t  out_addr_r;
  prefix_code_t out_code_r;
  logic         out_ok_r;

  addr_bytes_t in_addr;
  class_t      in_cls;
  logic        s2_ok_nxt;
  addr_bytes_t out_addr_nxt;

  logic out_adv, s2_adv, s1_adv;

  // a stage loads when it is empty or its content moves on in the same cycle
  assign out_adv  = !out_v_r || !out_stall;
  assign s2_adv   = !s2_v_r || out_adv;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_stall = !s1_adv;

  assign in_addr = {in_synth_addr_hi, in_synth_addr_lo};

  n64as_classify u_classify (
    .addr (in_addr),
    .cls  (in_cls)
  );

  // u-octet must be zero for the prefixes that straddle byte 8
  always_comb begin
    if (s1_cls_r.code == PFX_UNREC) begin
      s2_ok_nxt = 1'b0;
    end else begin
      s2_ok_nxt = is_wk(pick_v4(s1_addr_r, s1_cls_r.code)) &&
                  (!s1_cls_r.u_octet || (s1_addr_r[8] == 8'd0));
    end
  end

  assign out_addr_nxt = place_v4(s2_addr_r, s2_v4_r, s2_cls_r.code, s2_cls_r.u_octet);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_addr_r <= in_addr;
      s1_v4_r   <= in_ipv4_addr;
      s1_cls_r  <= in_cls;
    end
    if (s2_adv) begin
      s2_addr_r <= s1_addr_r;
      s2_v4_r   <= s1_v4_r;
      s2_cls_r  <= s1_cls_r;
      s2_ok_r   <= s2_ok_nxt;
    end
    if (out_adv) begin
      out_addr_r <= out_addr_nxt;
      out_code_r <= s2_cls_r.code;
      out_ok_r   <= s2_ok_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_result_addr_hi = out_addr_r[0:7];
  assign out_result_addr_lo = out_addr_r[8:15];
  assign out_prefix_code    = out_code_r;
  assign out_addr_valid     = out_ok_r;

  // a valid flag never comes with an unrecognized prefix
  a_valid_needs_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_ok_r && (out_code_r == PFX_UNREC)))
    else $error("addr_valid set with unrecognized prefix");

  // an empty output stage never backs up the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> !in_stall)
    else $error("input stalled while output stage empty");

  // a held middle stage keeps its transaction
  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_adv) |=> (s2_v_r && $stable(s2_addr_r) && $stable(s2_ok_r)))
    else $error("middle stage lost or changed a held transaction");

  // u-octet is cleared in the result wherever it is part of the placement
  a_u_octet_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && ((out_code_r == PFX_40) || (out_code_r == PFX_48) ||
                 (out_code_r == PFX_56))) |-> (out_addr_r[8] == 8'd0))
    else $error("u-octet not cleared");

endmodule
